FILE: src/assert_macros.svh
// Assertion macros shared by the heading pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on aclk, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication on aclk, off during reset
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/hdg_pkg.sv
// Types, constants and arctangent table for the heading pipeline
package hdg_pkg;

    localparam int RED_W     = 40;
    localparam int ANG_W     = 34;
    localparam int AT_W      = 53;
    localparam int RED_STEPS = 3;
    localparam int TABLE_LEN = 24;

    localparam logic signed [RED_W-1:0] PI_Q30      = 40'sd3373259426;
    localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 40'sd6746518852;
    localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 40'sd1686629713;

    localparam logic signed [ANG_W-1:0] PI_A      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_A = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] GAIN_A    = 34'sd652032874;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_TILT_ENABLE = 1'b0;
    localparam reg_idx_t REG_DECLINATION = 1'b1;

    typedef struct packed {
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } trig_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 34'sh03243F6A8;
            1:       v = 34'sh01DAC6705;
            2:       v = 34'sh00FADBAFC;
            3:       v = 34'sh007F56EA6;
            4:       v = 34'sh003FEAB76;
            5:       v = 34'sh001FFD55B;
            6:       v = 34'sh000FFFAAA;
            7:       v = 34'sh0007FFF55;
            8:       v = 34'sh0003FFFEA;
            9:       v = 34'sh0001FFFFD;
            10:      v = 34'sh0000FFFFF;
            11:      v = 34'sh00007FFFF;
            12:      v = 34'sh00003FFFF;
            13:      v = 34'sh00001FFFF;
            14:      v = 34'sh00000FFFF;
            15:      v = 34'sh000007FFF;
            16:      v = 34'sh000003FFF;
            17:      v = 34'sh000001FFF;
            18:      v = 34'sh000000FFF;
            19:      v = 34'sh0000007FF;
            20:      v = 34'sh0000003FF;
            21:      v = 34'sh0000001FF;
            22:      v = 34'sh0000000FF;
            23:      v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [RED_W-1:0] red_step(input int unsigned k);
        return RED_W'(TWO_PI_Q30) << (RED_STEPS - 1 - k);
    endfunction

endpackage

FILE: src/tilt_compensated_heading.sv
// Tilt compensated compass heading pipeline, top level
//  channel   dir  word fields (low bit first)
//  s_        in   mag_x, mag_y, mag_z, roll_angle, pitch_angle (16 b each)
//  m_        out  heading (16 b)
//  apb       in   0x0 tilt_enable, 0x4 declination
// One word enters per cycle while the skid stage is empty; both CORDIC chains
// do one micro-rotation per stage.
// Reset clears valid bits and the config registers only; no clearing pass.
// A stalled result waits in the output register, the next in a skid stage;
// s_tready falls only while the skid stage is full, and then the whole pipe holds.
`include "assert_macros.svh"
module tilt_compensated_heading #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // mag_x, mag_y, mag_z, roll_angle, pitch_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // heading
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PORT_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int AW  = hdg_pkg::ANG_W;
    localparam int VW  = hdg_pkg::AT_W;
    localparam int LSC = CORDIC_STEPS + 8;
    localparam logic signed [AW-1:0] HALF_LSB = AW'(64'sd1 <<< (PORT_SHIFT - 1));
    localparam logic signed [AW-1:0] PI_P =
        AW'((hdg_pkg::PI_Q30 + (40'sd1 <<< (PORT_SHIFT - 1))) >>> PORT_SHIFT);
    localparam logic signed [AW-1:0] TWO_PI_P =
        AW'((hdg_pkg::TWO_PI_Q30 + (40'sd1 <<< (PORT_SHIFT - 1))) >>> PORT_SHIFT);

    logic        tilt_reg;
    logic [15:0] decl_reg;
    logic        adv;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_reg <= 1'b1;
            decl_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (hdg_pkg::reg_idx_t'(paddr[2]))
                hdg_pkg::REG_TILT_ENABLE: tilt_reg <= pwdata[0];
                hdg_pkg::REG_DECLINATION: decl_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (hdg_pkg::reg_idx_t'(paddr[2]))
            hdg_pkg::REG_TILT_ENABLE: prdata = {31'b0, tilt_reg};
            hdg_pkg::REG_DECLINATION: prdata = {16'b0, decl_reg};
            default:                  prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // trig lanes
    logic           in_go;
    logic           roll_vld, pitch_vld;
    hdg_pkg::trig_t roll_trig, pitch_trig;
    logic [47:0]    mag_dly_reg [0:LSC-1];

    assign in_go = s_tvalid && s_tready;

    hdg_sincos #(.STEPS(CORDIC_STEPS), .SHIFT(PORT_SHIFT)) u_roll (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(in_go),
        .in_angle(s_tdata[63:48]), .out_valid(roll_vld), .out_trig(roll_trig)
    );

    hdg_sincos #(.STEPS(CORDIC_STEPS), .SHIFT(PORT_SHIFT)) u_pitch (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(in_go),
        .in_angle(s_tdata[79:64]), .out_valid(pitch_vld), .out_trig(pitch_trig)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_dly_reg[0] <= s_tdata[47:0];
            for (int k = 1; k < LSC; k++) begin
                mag_dly_reg[k] <= mag_dly_reg[k-1];
            end
        end
    end

    // projection
    logic signed [15:0] mx1, my1, mz1;
    logic signed [63:0] srsp_prod_reg, srcp_prod_reg;
    logic signed [47:0] xc_reg, zs_reg, yc1_reg, yc2_reg;
    logic [47:0]        mag1_reg, mag2_reg;
    logic signed [33:0] srsp, srcp;
    logic signed [49:0] xs_reg, zc_reg;
    logic signed [48:0] xh_reg;
    logic signed [50:0] yh;
    logic signed [VW-1:0] at_x_reg, at_y_reg;
    logic               p1_vld_reg, p2_vld_reg, p3_vld_reg;

    assign mx1 = mag_dly_reg[LSC-1][15:0];
    assign my1 = mag_dly_reg[LSC-1][31:16];
    assign mz1 = mag_dly_reg[LSC-1][47:32];
    assign srsp = 34'(srsp_prod_reg >>> 30);
    assign srcp = 34'(srcp_prod_reg >>> 30);
    assign yh   = 51'(xs_reg) + 51'(yc2_reg) - 51'(zc_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            srsp_prod_reg <= roll_trig.sin_v * pitch_trig.sin_v;
            srcp_prod_reg <= roll_trig.sin_v * pitch_trig.cos_v;
            xc_reg        <= mx1 * pitch_trig.cos_v;
            zs_reg        <= mz1 * pitch_trig.sin_v;
            yc1_reg       <= my1 * roll_trig.cos_v;
            mag1_reg      <= mag_dly_reg[LSC-1];

            xs_reg   <= signed'(mag1_reg[15:0]) * srsp;
            zc_reg   <= signed'(mag1_reg[47:32]) * srcp;
            xh_reg   <= 49'(xc_reg) + 49'(zs_reg);
            yc2_reg  <= yc1_reg;
            mag2_reg <= mag1_reg;

            if (tilt_reg) begin
                at_x_reg <= VW'(xh_reg);
                at_y_reg <= -(VW'(yh));
            end else begin
                at_x_reg <= VW'(signed'(mag2_reg[15:0])) <<< 30;
                at_y_reg <= VW'(signed'(mag2_reg[31:16])) <<< 30;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= roll_vld && pitch_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    // heading angle
    logic                 at_vld;
    logic signed [AW-1:0] at_ang;

    hdg_atan2 #(.STEPS(CORDIC_STEPS)) u_atan2 (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(p3_vld_reg),
        .in_x(at_x_reg), .in_y(at_y_reg), .out_valid(at_vld), .out_angle(at_ang)
    );

    // declination, wrap and saturation
    logic signed [AW-1:0] e1_h_reg;
    logic                 e1_vld_reg, e2_valid_reg;
    logic signed [AW-1:0] wrap_h;
    logic [15:0]          e2_next, e2_heading_reg;

    always_comb begin
        if (e1_h_reg > PI_P) begin
            wrap_h = e1_h_reg - TWO_PI_P;
        end else if (e1_h_reg < -PI_P) begin
            wrap_h = e1_h_reg + TWO_PI_P;
        end else begin
            wrap_h = e1_h_reg;
        end
        if (wrap_h > AW'(32767)) begin
            e2_next = 16'h7FFF;
        end else if (wrap_h < -AW'(32768)) begin
            e2_next = 16'h8000;
        end else begin
            e2_next = wrap_h[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_h_reg       <= ((at_ang + HALF_LSB) >>> PORT_SHIFT) + AW'(signed'(decl_reg));
            e2_heading_reg <= e2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg   <= 1'b0;
            e2_valid_reg <= 1'b0;
        end else if (adv) begin
            e1_vld_reg   <= at_vld;
            e2_valid_reg <= e1_vld_reg;
        end
    end

    // output register and skid stage
    logic        m_tvalid_reg, skid_valid_reg;
    logic [15:0] m_heading_reg, skid_heading_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_heading_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= e2_valid_reg;
            end
        end else if (adv && e2_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_heading_reg <= skid_valid_reg ? skid_heading_reg : e2_heading_reg;
        end else if (adv && e2_valid_reg) begin
            skid_heading_reg <= e2_heading_reg;
        end
    end

    `ASSERT_IMP(a_skid_behind_out, skid_valid_reg, m_tvalid_reg)
    `ASSERT_NXT(a_skid_holds, skid_valid_reg && !m_tready,
                skid_valid_reg && $stable(skid_heading_reg))
    `ASSERT_NXT(a_pipe_frozen, skid_valid_reg && e2_valid_reg,
                e2_valid_reg && $stable(e2_heading_reg))

endmodule

FILE: src/hdg_sincos.sv
// Angle reduction and rotation CORDIC pipeline giving sine and cosine
module hdg_sincos #(
    parameter int STEPS = 16,
    parameter int SHIFT = 17
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [15:0] in_angle,
    output logic               out_valid,
    output hdg_pkg::trig_t     out_trig
);
    localparam int RW   = hdg_pkg::RED_W;
    localparam int AW   = hdg_pkg::ANG_W;
    localparam int NRED = hdg_pkg::RED_STEPS;
    localparam int LAT  = STEPS + NRED + 5;

    logic signed [RW-1:0] ext;
    logic [RW-1:0]        abs_next;

    logic [RW-1:0]        mag_reg [0:NRED];
    logic [NRED:0]        sgn_reg;
    logic signed [AW-1:0] wrap_reg;
    logic                 wsgn_reg;
    logic signed [AW-1:0] fold_reg;
    logic                 fsgn_reg;
    logic                 fneg_reg;
    logic signed [AW-1:0] x_reg [0:STEPS];
    logic signed [AW-1:0] y_reg [0:STEPS];
    logic signed [AW-1:0] r_reg [0:STEPS];
    logic [STEPS:0]       neg_reg;
    logic [LAT-1:0]       vld_reg;
    hdg_pkg::trig_t       trig_reg;

    assign ext      = RW'(in_angle) <<< SHIFT;
    assign abs_next = ext[RW-1] ? RW'(-ext) : RW'(ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg[0] <= abs_next;
            sgn_reg[0] <= ext[RW-1];
            for (int k = 0; k < NRED; k++) begin
                mag_reg[k+1] <= (mag_reg[k] >= hdg_pkg::red_step(k)) ?
                                mag_reg[k] - hdg_pkg::red_step(k) : mag_reg[k];
                sgn_reg[k+1] <= sgn_reg[k];
            end
            wrap_reg <= (mag_reg[NRED] > RW'(hdg_pkg::PI_Q30)) ?
                        AW'(mag_reg[NRED] - RW'(hdg_pkg::TWO_PI_Q30)) : AW'(mag_reg[NRED]);
            wsgn_reg <= sgn_reg[NRED];
            if (wrap_reg > hdg_pkg::HALF_PI_A) begin
                fold_reg <= wrap_reg - hdg_pkg::PI_A;
                fneg_reg <= 1'b1;
            end else if (wrap_reg < -hdg_pkg::HALF_PI_A) begin
                fold_reg <= wrap_reg + hdg_pkg::PI_A;
                fneg_reg <= 1'b1;
            end else begin
                fold_reg <= wrap_reg;
                fneg_reg <= 1'b0;
            end
            fsgn_reg   <= wsgn_reg;
            r_reg[0]   <= fsgn_reg ? -fold_reg : fold_reg;
            x_reg[0]   <= hdg_pkg::GAIN_A;
            y_reg[0]   <= '0;
            neg_reg[0] <= fneg_reg;
            trig_reg.cos_v <= 32'(neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS]);
            trig_reg.sin_v <= 32'(neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS]);
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!r_reg[i][AW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] - hdg_pkg::atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] + hdg_pkg::atan_q30(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_trig  = trig_reg;

endmodule

FILE: src/hdg_atan2.sv
// Vectoring CORDIC pipeline giving atan2 of a wide vector
module hdg_atan2 #(
    parameter int STEPS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic signed [hdg_pkg::AT_W-1:0]  in_x,
    input  logic signed [hdg_pkg::AT_W-1:0]  in_y,
    output logic                             out_valid,
    output logic signed [hdg_pkg::ANG_W-1:0] out_angle
);
    localparam int VW  = hdg_pkg::AT_W;
    localparam int AW  = hdg_pkg::ANG_W;
    localparam int LAT = STEPS + 2;

    logic signed [VW-1:0] x_reg [0:STEPS];
    logic signed [VW-1:0] y_reg [0:STEPS];
    logic signed [AW-1:0] z_reg [0:STEPS];
    logic [STEPS:0]       zero_reg;
    logic [LAT-1:0]       vld_reg;
    logic signed [AW-1:0] ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (in_x[VW-1] && !in_y[VW-1]) begin
                x_reg[0] <= in_y;
                y_reg[0] <= -in_x;
                z_reg[0] <= hdg_pkg::HALF_PI_A;
            end else if (in_x[VW-1]) begin
                x_reg[0] <= -in_y;
                y_reg[0] <= in_x;
                z_reg[0] <= -hdg_pkg::HALF_PI_A;
            end else begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                z_reg[0] <= '0;
            end
            ang_reg <= zero_reg[STEPS] ? '0 : z_reg[STEPS];
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!y_reg[i][VW-1] && (y_reg[i] != '0)) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + hdg_pkg::atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - hdg_pkg::atan_q30(i);
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_angle = ang_reg;

endmodule

FILE: tb/tilt_compensated_heading_test.sv
// Self-checking testbench for the tilt compensated heading pipeline
`timescale 1ns / 100ps
module tilt_compensated_heading_test;

    localparam int STEPS = 16;
    localparam int FRAC = 13;
    localparam int SHIFT = 30 - FRAC;
    localparam int LATENCY = 2 * STEPS + 16;
    localparam int WATCHDOG = 5000;
    localparam longint P_PI = 64'sd3373259426;
    localparam longint P_2PI = 64'sd6746518852;
    localparam longint P_HPI = 64'sd1686629713;
    localparam longint P_GAIN = 64'sd652032874;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] mz;
        logic signed [15:0] my;
        logic signed [15:0] mx;
    } sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [79:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tilt_compensated_heading #(.CORDIC_STEPS(STEPS), .ANGLE_FRAC_BITS(FRAC)) u_dut (.*);

    sample_t pending_samples[$];
    logic signed [15:0] expected_headings[$];
    logic tilt_on = 1'b1;
    logic signed [15:0] decl = '0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int headings_seen = 0;
    int quiet_cycles = 0;
    bit timed_out = 0;

    longint atan_tab[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic rotate_trig(input longint ang, output longint c, output longint s);
        longint r, x, y, nx;
        bit neg;
        r = ang % P_2PI;
        x = P_GAIN;
        y = 0;
        neg = 0;
        if (r > P_PI) r -= P_2PI;
        if (r < -P_PI) r += P_2PI;
        if (r > P_HPI) begin
            r -= P_PI;
            neg = 1;
        end else if (r < -P_HPI) begin
            r += P_PI;
            neg = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                r -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                r += atan_tab[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic longint vector_angle(input longint yi, input longint xi);
        longint x, y, z, t;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = P_HPI;
            end else begin
                t = x; x = -y; y = t; z = -P_HPI;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_tab[i];
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = t;
        end
        return z;
    endfunction

    function automatic longint to_port(input longint v);
        return (v + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
    endfunction

    task automatic predict_heading(input sample_t smp);
        longint cr, sr, cp, sp, srsp, srcp, xh, yh, ang, h, mx, my, mz;
        mx = smp.mx;
        my = smp.my;
        mz = smp.mz;
        if (tilt_on) begin
            rotate_trig(longint'(smp.roll) <<< SHIFT, cr, sr);
            rotate_trig(longint'(smp.pitch) <<< SHIFT, cp, sp);
            srsp = (sr * sp) >>> 30;
            srcp = (sr * cp) >>> 30;
            xh = mx * cp + mz * sp;
            yh = mx * srsp + my * cr - mz * srcp;
            ang = vector_angle(-yh, xh);
        end else begin
            ang = vector_angle(my <<< 30, mx <<< 30);
        end
        h = to_port(ang) + longint'(decl);
        if (h > to_port(P_PI)) h -= to_port(P_2PI);
        else if (h < -to_port(P_PI)) h += to_port(P_2PI);
        if (h > 32767) h = 32767;
        if (h < -32768) h = -32768;
        expected_headings.push_back(16'(h));
    endtask

    function automatic sample_t random_sample(input bit wide_angles);
        sample_t smp;
        smp.mx = $urandom;
        smp.my = $urandom;
        smp.mz = $urandom;
        if (wide_angles) begin
            smp.roll = $urandom;
            smp.pitch = $urandom;
        end else begin
            smp.roll = $urandom_range(0, 2 * 25736) - 25736;
            smp.pitch = $urandom_range(0, 2 * 25736) - 25736;
        end
        if ($urandom_range(0, 9) == 0) smp.mx = 0;
        if ($urandom_range(0, 9) == 0) smp.my = 0;
        return smp;
    endfunction

    task automatic apb_write(input hdg_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == hdg_pkg::REG_TILT_ENABLE) tilt_on = val[0];
        else decl = val[15:0];
    endtask

    task automatic drain;
        while (pending_samples.size() != 0 || expected_headings.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_heading(s_tdata);
            end
            if (!(s_tvalid && !s_tready) && pending_samples.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_samples.pop_front();
            end else if (!(s_tvalid && !s_tready)) begin
                s_tvalid <= 1'b0;
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                headings_seen++;
                if (expected_headings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected heading %0d", $signed(m_tdata));
                end else if (m_tdata !== expected_headings[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("heading mismatch: expected %0d got %0d",
                                 expected_headings[0], $signed(m_tdata));
                    void'(expected_headings.pop_front());
                end else begin
                    void'(expected_headings.pop_front());
                end
            end
            if (!((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG && !timed_out) begin
                    timed_out = 1;
                    $display("watchdog expired, %0d headings outstanding",
                             expected_headings.size());
                    $display("tb: failure");
                    $finish;
                end
            end else begin
                quiet_cycles = 0;
            end
        end
    end

    initial begin
        sample_t smp;
        int idle_mix[4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{7, 7}};
        int decl_mix[4] = '{0, 25736, -25736, 12000};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero vector, wide angles, both modes
        for (int mode = 1; mode >= 0; mode--) begin
            apb_write(hdg_pkg::REG_TILT_ENABLE, 32'(mode));
            foreach (decl_mix[d]) begin
                apb_write(hdg_pkg::REG_DECLINATION, 32'(decl_mix[d]));
                smp = '0;
                pending_samples.push_back(smp);
                smp = '{pitch: 16'sh7FFF, roll: -16'sh8000, mz: 16'sh7FFF,
                        my: -16'sh8000, mx: 16'sh7FFF};
                pending_samples.push_back(smp);
                smp = '{pitch: 25736, roll: -25736, mz: -32768,
                        my: 32767, mx: -32768};
                pending_samples.push_back(smp);
                smp = '{pitch: 0, roll: 0, mz: 0, my: 0, mx: -100};
                pending_samples.push_back(smp);
                drain();
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            apb_write(hdg_pkg::REG_TILT_ENABLE, (ph == 2) ? 32'd0 : 32'd1);
            apb_write(hdg_pkg::REG_DECLINATION,
                      32'($urandom_range(0, 2 * 25736) - 25736));
            send_idle_pct = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            for (int i = 0; i < 100; i++)
                pending_samples.push_back(random_sample($urandom_range(0, 3) == 0));
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        $display("checked %0d headings over both modes, four declinations and four idle mixes",
                 headings_seen);
        if (mismatches == 0 && expected_headings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/hdg_pkg.sv
src/hdg_sincos.sv
src/hdg_atan2.sv
src/tilt_compensated_heading.sv
tb/tilt_compensated_heading_test.sv
